/* sv/bcmru_pkg.sv */
// ----------------------------------------------------------------------------
// bcmru_pkg
// Shared types and codes of the block cache with MRU replacement.
// ----------------------------------------------------------------------------
package bcmru_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_MISS    = 3'd1;
	localparam logic [2:0] ST_WRITTEN = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	localparam int DISK_W  = 4;
	localparam int BLOCK_W = 8;
	localparam int WORD_W  = 5;
	localparam int DATA_W  = 64;
	localparam int CFG_W   = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;     // capture the input item
		logic decide;    // update tags and run state, write data word
		logic rd_start;  // load the read word counter
		logic rd_next;   // advance the read word counter
	} bcmru_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] status;  // single-result status of the latched item
		logic       is_hit;  // lookup hit: a run of words follows
		logic       rd_last; // RAM output at the final word
	} bcmru_stat_t;

endpackage

/* sv/block_cache_mru_replacement_core.sv */
// An accepted item is latched; a single result is registered in the decide state, and a
// lookup hit then reads its block through the read-address and read-data states, streaming
// one word a cycle while results are taken. A new item is accepted only in the idle state,
// after the last result has been loaded. Result stalls hold the controller.
// Reset clears tags, valid bits and run state at once; block data is undefined until written.
// ----------------------------------------------------------------------------
// block_cache_mru_replacement_core
// Fully associative disk-block cache with most-recently-used replacement.
// ----------------------------------------------------------------------------
module block_cache_mru_replacement_core #(
	parameter int ENTRIES         = 64,
	parameter int DISKS           = 16,
	parameter int BLOCKS_PER_DISK = 256,
	parameter int BLOCK_WORDS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [3:0]  disk_number,
	input  logic [7:0]  block_number,
	input  logic [4:0]  word_index,
	input  logic [63:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] read_word,
	output logic [4:0]  read_index,
	output logic        last_of_run
);

	logic [bcmru_pkg::CFG_W-1:0] active_entries_q;
	bcmru_pkg::bcmru_cmd_t       cmd_w;
	bcmru_pkg::bcmru_stat_t      stat_w;
	logic [63:0]                 rd_word;
	logic [4:0]                  rd_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_entries_q <= bcmru_pkg::CFG_W'(ENTRIES > 127 ? 127 : ENTRIES);
		end else if (cfg_we) begin
			active_entries_q <= cfg_wdata;
		end
	end

	bcmru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ctrl_cmd    (cmd_w),
		.dp_stat     (stat_w),
		.rd_word     (rd_word),
		.rd_index    (rd_index),
		.status      (status),
		.read_word   (read_word),
		.read_index  (read_index),
		.last_of_run (last_of_run)
	);

	bcmru_dp #(
		.ENTRIES         (ENTRIES),
		.DISKS           (DISKS),
		.BLOCKS_PER_DISK (BLOCKS_PER_DISK),
		.BLOCK_WORDS     (BLOCK_WORDS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl_cmd         (cmd_w),
		.dp_stat          (stat_w),
		.active_entries_q (active_entries_q),
		.cmd              (cmd),
		.disk_number      (disk_number),
		.block_number     (block_number),
		.word_index       (word_index),
		.data_word        (data_word),
		.rd_word          (rd_word),
		.rd_index         (rd_index)
	);

endmodule

/* sv/bcmru_ram.sv */
// ----------------------------------------------------------------------------
// bcmru_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcmru_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* sv/bcmru_dp.sv */
// ----------------------------------------------------------------------------
// bcmru_dp
// Datapath: tag store, parallel tag match, victim choice and block data RAM.
// ----------------------------------------------------------------------------
module bcmru_dp #(
	parameter int ENTRIES         = 64,
	parameter int DISKS           = 16,
	parameter int BLOCKS_PER_DISK = 256,
	parameter int BLOCK_WORDS     = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcmru_pkg::bcmru_cmd_t         ctrl_cmd,
	output bcmru_pkg::bcmru_stat_t        dp_stat,
	input  logic [bcmru_pkg::CFG_W-1:0]   active_entries_q,
	input  logic [1:0]                    cmd,
	input  logic [bcmru_pkg::DISK_W-1:0]  disk_number,
	input  logic [bcmru_pkg::BLOCK_W-1:0] block_number,
	input  logic [bcmru_pkg::WORD_W-1:0]  word_index,
	input  logic [bcmru_pkg::DATA_W-1:0]  data_word,
	output logic [bcmru_pkg::DATA_W-1:0]  rd_word,
	output logic [bcmru_pkg::WORD_W-1:0]  rd_index
);

	localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BWW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int AW  = $clog2(ENTRIES * BLOCK_WORDS);
	localparam int EW  = $clog2(ENTRIES + 1);
	localparam int NW  = ((EW > bcmru_pkg::CFG_W) ? EW : bcmru_pkg::CFG_W) + 1;

	logic [1:0]                    cmd_q;
	logic [bcmru_pkg::DISK_W-1:0]  disk_q;
	logic [bcmru_pkg::BLOCK_W-1:0] blk_q;
	logic [bcmru_pkg::WORD_W-1:0]  widx_q;
	logic [bcmru_pkg::DATA_W-1:0]  data_q;

	logic                          valid_q [ENTRIES];
	logic [bcmru_pkg::DISK_W-1:0]  tdisk_q [ENTRIES];
	logic [bcmru_pkg::BLOCK_W-1:0] tblk_q  [ENTRIES];
	logic [SW-1:0]                 recent_q, run_slot_q;
	logic [1:0]                    run_mode_q;
	logic [BWW-1:0]                rcnt_q;
	logic [BWW-1:0]                ridx_q;

	logic [NW-1:0] n_act;
	logic          hit, free_found;
	logic [SW-1:0] hit_slot, free_slot, victim, slot_sel;
	logic          run_ok, bad_addr, bad_word;
	logic          do_write;
	logic [2:0]    st;

	logic [SW-1:0]  ram_slot;
	logic [AW-1:0]  ram_addr;
	logic [BWW-1:0] ram_word;

	always_comb begin
		if (NW'(active_entries_q) < NW'(2)) begin
			n_act = NW'(2);
		end else if (NW'(active_entries_q) > NW'(ENTRIES)) begin
			n_act = NW'(ENTRIES);
		end else begin
			n_act = NW'(active_entries_q);
		end
	end

	// Parallel match and lowest free slot search.
	always_comb begin
		hit        = 1'b0;
		hit_slot   = '0;
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (NW'(i) < n_act) begin
				if (valid_q[i] && tdisk_q[i] == disk_q && tblk_q[i] == blk_q) begin
					hit      = 1'b1;
					hit_slot = SW'(i);
				end
				if (!valid_q[i]) begin
					free_found = 1'b1;
					free_slot  = SW'(i);
				end
			end
		end
	end

	always_comb begin
		victim   = (NW'(recent_q) < n_act) ? recent_q : '0;
		bad_addr = (cmd_q == bcmru_pkg::CMD_RSVD) || (32'(disk_q) >= DISKS) ||
			(32'(blk_q) >= BLOCKS_PER_DISK);
		bad_word = (32'(widx_q) >= BLOCK_WORDS);
		run_ok   = (run_mode_q == cmd_q) && (NW'(run_slot_q) < n_act) &&
			valid_q[run_slot_q] && tdisk_q[run_slot_q] == disk_q &&
			tblk_q[run_slot_q] == blk_q;
		slot_sel = hit ? hit_slot : (free_found ? free_slot : victim);
		do_write = 1'b0;
		if (bad_addr) begin
			st = bcmru_pkg::ST_INVALID;
		end else if (cmd_q == bcmru_pkg::CMD_LOOKUP) begin
			st = hit ? bcmru_pkg::ST_HIT : bcmru_pkg::ST_MISS;
		end else if (bad_word) begin
			st = bcmru_pkg::ST_INVALID;
		end else if (widx_q == '0) begin
			if (!hit && cmd_q == bcmru_pkg::CMD_UPDATE) begin
				st = bcmru_pkg::ST_ABSENT;
			end else begin
				st       = bcmru_pkg::ST_WRITTEN;
				do_write = 1'b1;
			end
		end else if (!run_ok) begin
			st = bcmru_pkg::ST_ABSENT;
		end else begin
			st       = bcmru_pkg::ST_WRITTEN;
			do_write = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.latch) begin
			cmd_q  <= cmd;
			disk_q <= disk_number;
			blk_q  <= block_number;
			widx_q <= word_index;
			data_q <= data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				tdisk_q[i] <= '0;
				tblk_q[i]  <= '0;
			end
			recent_q   <= '0;
			run_slot_q <= '0;
			run_mode_q <= '0;
			rcnt_q     <= '0;
		end else begin
			if (ctrl_cmd.decide) begin
				if (st == bcmru_pkg::ST_HIT) begin
					recent_q <= hit_slot;
				end else if (!bad_addr && !bad_word && widx_q == '0 &&
						cmd_q != bcmru_pkg::CMD_LOOKUP) begin
					if (do_write) begin
						if (!hit) begin
							valid_q[slot_sel] <= 1'b1;
							tdisk_q[slot_sel] <= disk_q;
							tblk_q[slot_sel]  <= blk_q;
						end
						run_slot_q <= slot_sel;
						run_mode_q <= cmd_q;
						recent_q   <= slot_sel;
					end else begin
						run_mode_q <= '0;
					end
				end else if (do_write) begin
					recent_q <= run_slot_q;
				end
			end
			if (ctrl_cmd.rd_start) begin
				rcnt_q <= '0;
			end else if (ctrl_cmd.rd_next) begin
				rcnt_q <= rcnt_q + 1'b1;
			end
		end
	end

	// Data RAM: written at decide, otherwise addressed by the read counter. While the
	// read-out is held, the word already on the output is read again.
	always_comb begin
		if (ctrl_cmd.decide) begin
			ram_slot = (widx_q == '0) ? slot_sel : run_slot_q;
			ram_word = BWW'(widx_q);
		end else begin
			ram_slot = recent_q;
			ram_word = ctrl_cmd.rd_next ? rcnt_q : ridx_q;
		end
		ram_addr = AW'(ram_slot) * AW'(BLOCK_WORDS) + AW'(ram_word);
	end

	bcmru_ram #(.WIDTH(bcmru_pkg::DATA_W), .DEPTH(ENTRIES * BLOCK_WORDS)) u_ram (
		.clk   (clk),
		.we    (ctrl_cmd.decide && do_write),
		.addr  (ram_addr),
		.wdata (data_q),
		.rdata (rd_word)
	);

	// Index of the word now on the RAM output.
	always_ff @(posedge clk) begin
		ridx_q <= ram_word;
	end
	assign rd_index = bcmru_pkg::WORD_W'(ridx_q);

	assign dp_stat.status  = st;
	assign dp_stat.is_hit  = (st == bcmru_pkg::ST_HIT);
	assign dp_stat.rd_last = (32'(ridx_q) == BLOCK_WORDS - 1);

endmodule

/* sv/bcmru_ctrl.sv */
// ----------------------------------------------------------------------------
// bcmru_ctrl
// Controller: sequences accept, decision, block read-out and result hand-off.
// ----------------------------------------------------------------------------
module bcmru_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bcmru_pkg::bcmru_cmd_t   ctrl_cmd,
	input  bcmru_pkg::bcmru_stat_t  dp_stat,
	input  logic [63:0]             rd_word,
	input  logic [4:0]              rd_index,
	output logic [2:0]              status,
	output logic [63:0]             read_word,
	output logic [4:0]              read_index,
	output logic                    last_of_run
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RADDR  = 3'd2;
	localparam logic [2:0] S_RDATA  = 3'd3;

	logic [2:0]  state_q;
	logic        ovalid_q;
	logic        more_q;
	logic        obuf_free;
	logic        load_single;
	logic        load_word;
	logic [2:0]  status_q;
	logic [63:0] rword_q;
	logic [4:0]  rindex_q;
	logic        last_q;

	assign obuf_free   = !ovalid_q || out_ready;
	assign out_valid   = ovalid_q;
	assign in_ready    = (state_q == S_IDLE);
	assign load_single = (state_q == S_DECIDE) && obuf_free && !dp_stat.is_hit;
	assign load_word   = (state_q == S_RDATA) && obuf_free;

	assign status      = status_q;
	assign read_word   = rword_q;
	assign read_index  = rindex_q;
	assign last_of_run = last_q;

	always_comb begin
		ctrl_cmd          = '0;
		ctrl_cmd.latch    = (state_q == S_IDLE) && in_valid;
		ctrl_cmd.decide   = (state_q == S_DECIDE) && obuf_free;
		ctrl_cmd.rd_start = ctrl_cmd.decide && dp_stat.is_hit;
		// Counter leads the RAM output by one word.
		ctrl_cmd.rd_next  = (state_q == S_RADDR) ||
			((state_q == S_RDATA) && obuf_free && more_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			more_q   <= 1'b0;
			status_q <= '0;
			rword_q  <= '0;
			rindex_q <= '0;
			last_q   <= 1'b0;
		end else begin
			ovalid_q <= load_single || load_word || (ovalid_q && !out_ready);
			if (load_single) begin
				status_q <= dp_stat.status;
				rword_q  <= '0;
				rindex_q <= '0;
				last_q   <= 1'b1;
			end else if (load_word) begin
				status_q <= bcmru_pkg::ST_HIT;
				rword_q  <= rd_word;
				rindex_q <= rd_index;
				last_q   <= dp_stat.rd_last;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (obuf_free) begin
						state_q <= dp_stat.is_hit ? S_RADDR : S_IDLE;
					end
				end
				S_RADDR: begin
					more_q  <= 1'b1;
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					if (load_word && dp_stat.rd_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_block_cache_mru_replacement_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_cache_mru_replacement_core
// Self-checking bench for the disk-block cache: a directed table and cache-size cases
// followed by random write runs, lookups and noise, checked against a behavioural cache model.
// ----------------------------------------------------------------------------
module tb_block_cache_mru_replacement_core;

	localparam int NSLOT = 64;
	localparam int NWORD = 32;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  st;
		logic [63:0] word;
		logic [4:0]  idx;
		logic        last;
	} cache_res_t;

	typedef struct {
		logic [1:0]  c;
		logic [3:0]  d;
		logic [7:0]  b;
		logic [4:0]  w;
		logic [63:0] data;
		logic        chk;   // typed-in expectation present
		logic [2:0]  st;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [3:0]  disk_number = '0;
	logic [7:0]  block_number = '0;
	logic [4:0]  word_index = '0;
	logic [63:0] data_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [63:0] read_word;
	logic [4:0]  read_index;
	logic        last_of_run;

	// Shadow copy of the cache contents.
	logic        m_valid [NSLOT];
	logic [3:0]  m_disk [NSLOT];
	logic [7:0]  m_block [NSLOT];
	logic [63:0] m_data [NSLOT*NWORD];
	logic [NWORD-1:0] m_written [NSLOT];
	int          m_recent, m_run_slot;
	logic [1:0]  m_run_mode;
	logic [6:0]  m_active;

	cache_res_t  pending_results[$];
	int          errors = 0;
	int          cycles = 0;
	int          n_items = 0, n_results = 0, n_hits = 0;
	bit          rx_stall_mode = 0;
	// Blocks whose every word has been written; hits are only caused on these.
	logic [11:0] full_blocks[$];

	block_cache_mru_replacement_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.disk_number(disk_number), .block_number(block_number),
		.word_index(word_index), .data_word(data_word),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.read_word(read_word), .read_index(read_index), .last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int active_n();
		if (m_active < 2) return 2;
		if (m_active > NSLOT) return NSLOT;
		return int'(m_active);
	endfunction

	function automatic int lookup_slot(logic [3:0] d, logic [7:0] b);
		for (int i = 0; i < active_n(); i++)
			if (m_valid[i] && m_disk[i] == d && m_block[i] == b) return i;
		return -1;
	endfunction

	function automatic cache_res_t single(logic [2:0] st);
		cache_res_t r;
		r.st = st; r.word = '0; r.idx = '0; r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_cache(input logic [1:0] c, input logic [3:0] d,
			input logic [7:0] b, input logic [4:0] w, input logic [63:0] data);
		int n, s;
		cache_res_t r;
		n = active_n();
		s = lookup_slot(d, b);
		if (c == bcmru_pkg::CMD_RSVD) begin
			pending_results.push_back(single(bcmru_pkg::ST_INVALID));
		end else if (c == bcmru_pkg::CMD_LOOKUP) begin
			if (s < 0) begin
				pending_results.push_back(single(bcmru_pkg::ST_MISS));
			end else begin
				m_recent = s;
				n_hits++;
				for (int i = 0; i < NWORD; i++) begin
					r.st = bcmru_pkg::ST_HIT; r.word = m_data[s*NWORD+i]; r.idx = i[4:0];
					r.last = (i == NWORD-1);
					pending_results.push_back(r);
				end
			end
		end else if (w == 0) begin
			if (s < 0 && c == bcmru_pkg::CMD_UPDATE) begin
				m_run_mode = 2'd0;
				pending_results.push_back(single(bcmru_pkg::ST_ABSENT));
				return;
			end
			if (s < 0) begin
				for (int i = 0; i < n && s < 0; i++) if (!m_valid[i]) s = i;
				if (s < 0) s = (m_recent < n) ? m_recent : 0;
				m_valid[s] = 1'b1; m_disk[s] = d; m_block[s] = b;
				m_written[s] = '0;
			end
			m_run_slot = s; m_run_mode = c;
			m_data[s*NWORD] = data; m_written[s][0] = 1'b1; m_recent = s;
			pending_results.push_back(single(bcmru_pkg::ST_WRITTEN));
		end else begin
			s = m_run_slot;
			if (m_run_mode != c || s >= n || !(m_valid[s] && m_disk[s] == d &&
					m_block[s] == b)) begin
				pending_results.push_back(single(bcmru_pkg::ST_ABSENT));
				return;
			end
			m_data[s*NWORD+w] = data; m_written[s][w] = 1'b1; m_recent = s;
			pending_results.push_back(single(bcmru_pkg::ST_WRITTEN));
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
			n_results);
	endtask

	// Result checker.
	always @(posedge clk) begin
		cache_res_t e;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(status), 64'd0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st)
					report_mismatch("status", 64'(status), 64'(e.st));
				if (read_word !== e.word)
					report_mismatch("read_word", read_word, e.word);
				if (read_index !== e.idx)
					report_mismatch("read_index", 64'(read_index), 64'(e.idx));
				if (last_of_run !== e.last)
					report_mismatch("last_of_run", 64'(last_of_run), 64'(e.last));
			end
		end
	end

	// Receiver stalls: alternating stretches of steady readiness and a random pattern.
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
		out_ready <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
	end

	// The item stays on the port after acceptance until the next item or a gap replaces it.
	task automatic send_item(input logic [1:0] c, input logic [3:0] d,
			input logic [7:0] b, input logic [4:0] w, input logic [63:0] data);
		// Sender gaps come in bursts.
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c; disk_number <= d; block_number <= b; word_index <= w; data_word <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_cache(c, d, b, w, data);
		n_items++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_active(input logic [6:0] v);
		drain_results();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_active = v;
		// Keep only blocks still reachable and fully written.
		full_blocks.delete();
		for (int i = 0; i < active_n(); i++)
			if (m_valid[i] && &m_written[i]) full_blocks.push_back({m_disk[i], m_block[i]});
	endtask

	task automatic write_run(input logic [1:0] c, input logic [3:0] d, input logic [7:0] b,
			input int len);
		for (int i = 0; i < len; i++)
			send_item(c, d, b, 5'(i), {$urandom, $urandom});
	endtask

	function automatic bit block_complete(logic [3:0] d, logic [7:0] b);
		int s;
		s = lookup_slot(d, b);
		return s >= 0 && &m_written[s];
	endfunction

	stim_row_t dir_table[] = '{
		'{bcmru_pkg::CMD_LOOKUP, 4'd0,  8'd0,   5'd0,  64'h0, 1'b1, bcmru_pkg::ST_MISS},
		'{bcmru_pkg::CMD_LOOKUP, 4'd15, 8'd255, 5'd31, 64'h0, 1'b1, bcmru_pkg::ST_MISS},
		'{bcmru_pkg::CMD_RSVD,   4'd3,  8'd7,   5'd0,  64'h0, 1'b1, bcmru_pkg::ST_INVALID},
		'{bcmru_pkg::CMD_UPDATE, 4'd1,  8'd1,   5'd0,  64'h1, 1'b1, bcmru_pkg::ST_ABSENT},
		'{bcmru_pkg::CMD_INSERT, 4'd2,  8'd2,   5'd5,  64'h5, 1'b1, bcmru_pkg::ST_ABSENT},
		'{bcmru_pkg::CMD_INSERT, 4'd15, 8'd255, 5'd0,  64'hffffffffffffffff, 1'b1,
			bcmru_pkg::ST_WRITTEN},
		'{bcmru_pkg::CMD_INSERT, 4'd15, 8'd255, 5'd1,  64'h0, 1'b1, bcmru_pkg::ST_WRITTEN},
		'{bcmru_pkg::CMD_UPDATE, 4'd15, 8'd255, 5'd2,  64'h2, 1'b1, bcmru_pkg::ST_ABSENT},
		'{bcmru_pkg::CMD_INSERT, 4'd14, 8'd255, 5'd2,  64'h2, 1'b1, bcmru_pkg::ST_ABSENT},
		'{bcmru_pkg::CMD_LOOKUP, 4'd15, 8'd254, 5'd0,  64'h0, 1'b1, bcmru_pkg::ST_MISS},
		'{bcmru_pkg::CMD_UPDATE, 4'd15, 8'd255, 5'd0,  64'haaaa5555aaaa5555, 1'b0,
			bcmru_pkg::ST_WRITTEN},
		'{bcmru_pkg::CMD_UPDATE, 4'd15, 8'd255, 5'd31, 64'h5555aaaa5555aaaa, 1'b0,
			bcmru_pkg::ST_WRITTEN}
	};

	initial begin
		logic [3:0] d;
		logic [7:0] b;
		logic [11:0] key;
		for (int i = 0; i < NSLOT; i++) begin
			m_valid[i] = 1'b0; m_disk[i] = '0; m_block[i] = '0; m_written[i] = '0;
		end
		m_recent = 0; m_run_slot = 0; m_run_mode = 2'd0; m_active = 7'd64;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			send_item(dir_table[i].c, dir_table[i].d, dir_table[i].b,
				dir_table[i].w, dir_table[i].data);
			if (dir_table[i].chk && pending_results[$].st !== dir_table[i].st)
				report_mismatch("table entry", 64'(pending_results[$].st),
					64'(dir_table[i].st));
		end
		// Complete the block through the open update run, then read it out.
		for (int i = 1; i < NWORD; i++)
			send_item(bcmru_pkg::CMD_UPDATE, 4'd15, 8'd255, i[4:0], ~64'(i));
		send_item(bcmru_pkg::CMD_LOOKUP, 4'd15, 8'd255, 5'd0, 64'h0);
		// Sender holds off until the cache has answered everything.
		drain_results();

		// Smallest cache: overflow it so the most recent slot is replaced.
		set_active(7'd0);
		for (int k = 0; k < 4; k++)
			send_item(bcmru_pkg::CMD_INSERT, 4'(k), 8'(k), 5'd0, {$urandom, $urandom});
		send_item(bcmru_pkg::CMD_LOOKUP, 4'd2, 8'd2, 5'd0, 64'h0);
		send_item(bcmru_pkg::CMD_LOOKUP, 4'd15, 8'd255, 5'd0, 64'h0);
		set_active(7'd127);
		set_active(7'd3);
		for (int k = 0; k < 4; k++)
			send_item(bcmru_pkg::CMD_INSERT, 4'(k+4), 8'(k*9), 5'd0, {$urandom, $urandom});
		set_active(7'd64);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) set_active(7'($urandom_range(2, 10)));
			if (phase == 2) set_active(7'd64);
			if (phase == 0) begin
				write_run(bcmru_pkg::CMD_INSERT, 4'd1, 8'd3, NWORD);
				if (block_complete(4'd1, 8'd3)) full_blocks.push_back({4'd1, 8'd3});
			end
			for (int it = 0; it < 15; it++) begin
				d = 4'($urandom_range(0, 3)); b = 8'($urandom_range(0, 7));
				if ($urandom_range(0, 99) < 10) begin d = 4'($urandom); b = 8'($urandom); end
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						if (full_blocks.size() != 0 && $urandom_range(0, 1)) begin
							key = full_blocks[$urandom_range(0, full_blocks.size()-1)];
							d = key[11:8]; b = key[7:0];
						end
						if (lookup_slot(d, b) < 0 || block_complete(d, b))
							send_item(bcmru_pkg::CMD_LOOKUP, d, b, 5'($urandom),
								{$urandom, $urandom});
					end
					3, 4: begin
						write_run(bcmru_pkg::CMD_INSERT, d, b, $urandom_range(1, 4));
						if (block_complete(d, b)) full_blocks.push_back({d, b});
					end
					5: begin
						if (lookup_slot(d, b) >= 0)
							write_run(bcmru_pkg::CMD_UPDATE, d, b, $urandom_range(1, 4));
						else
							send_item(bcmru_pkg::CMD_UPDATE, d, b, 5'd0, {$urandom, $urandom});
					end
					default: begin
						// Noise: stray or broken run words, unused command.
						send_item(2'($urandom), d, b, 5'($urandom_range(1, 31)),
							{$urandom, $urandom});
					end
				endcase
				// Drop entries whose blocks were evicted or left partly written.
				for (int q = full_blocks.size()-1; q >= 0; q--)
					if (!block_complete(full_blocks[q][11:8], full_blocks[q][7:0]))
						full_blocks.delete(q);
			end
		end

		drain_results();
		$display("Covered %0d items, %0d results, %0d block read-outs.",
			n_items, n_results, n_hits);
		$display("Included sizes 2, 3, 64 and saturated settings, stray words and bad commands.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
